### sv/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types, palette tables and constants for the nearest palette color
// matcher.
// ----------------------------------------------------------------------------
package npc_pkg;

	localparam int NPC_QDEPTH = 2;

	typedef enum logic [2:0] {
		PM_XTERM256       = 3'd0,
		PM_XTERM256_NOSYS = 3'd1,
		PM_WIN256         = 3'd2,
		PM_XTERM88        = 3'd3,
		PM_XTERM16        = 3'd4
	} npc_mode_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} npc_bstate_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		npc_mode_t  mode;
		logic [7:0] lo;
		logic [7:0] last;
	} npc_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} npc_qstat_t;

	localparam logic [7:0] NPC_SYS_LEN    = 8'd16;
	localparam logic [7:0] NPC_CUBE4_END  = 8'd80;
	localparam logic [7:0] NPC_GREY8_LAST = 8'd87;
	localparam logic [7:0] NPC_CUBE6_END  = 8'd232;
	localparam logic [7:0] NPC_GREY24_LAST = 8'd255;
	localparam logic [7:0] NPC_GREY24_BASE = 8'd8;
	localparam logic [7:0] NPC_GREY24_STEP = 8'd10;

	localparam logic [23:0] NPC_XTERM_SYS [16] = '{
		24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
		24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
		24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
		24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
	};

	localparam logic [23:0] NPC_WIN_SYS [16] = '{
		24'h000000, 24'h000080, 24'h008000, 24'h008080,
		24'h800000, 24'h800080, 24'h808000, 24'hC0C0C0,
		24'h808080, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
		24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
	};

	localparam logic [7:0] NPC_CUBE6 [6] = '{8'h00, 8'h5F, 8'h87, 8'hAF, 8'hD7, 8'hFF};
	localparam logic [7:0] NPC_CUBE4 [4] = '{8'd0, 8'd139, 8'd205, 8'd255};
	localparam logic [7:0] NPC_GREY8 [8] = '{8'd46, 8'd92, 8'd113, 8'd139,
		8'd162, 8'd185, 8'd208, 8'd231};

endpackage

### sv/npc_front.sv
// ----------------------------------------------------------------------------
// npc_front
// Holds the palette mode register, accepts colors and classifies each one
// into the range of palette entries that the search has to visit.
// ----------------------------------------------------------------------------
module npc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_wr_data,
	input  npc_pkg::npc_qstat_t q_stat,
	output logic             push,
	output npc_pkg::npc_job_t push_job
);
	import npc_pkg::*;

	logic [2:0] mode_q;
	npc_mode_t  mode_c;
	logic       grey;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 3'd0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	always_comb begin
		mode_c = (mode_q > 3'(PM_XTERM16)) ? PM_XTERM256 : npc_mode_t'(mode_q);
		grey = (red == green) && (red == blue) && (red != 8'h00) && (red != 8'hFF);
		push = start && !q_stat.full;
		push_job.red   = red;
		push_job.green = green;
		push_job.blue  = blue;
		push_job.mode  = mode_c;
		unique case (mode_c)
			PM_XTERM16: begin
				push_job.lo   = 8'd0;
				push_job.last = NPC_SYS_LEN - 8'd1;
			end
			PM_XTERM88: begin
				push_job.lo   = grey ? NPC_CUBE4_END : 8'd0;
				push_job.last = grey ? NPC_GREY8_LAST : NPC_CUBE4_END - 8'd1;
			end
			PM_XTERM256_NOSYS: begin
				push_job.lo   = grey ? NPC_CUBE6_END : NPC_SYS_LEN;
				push_job.last = grey ? NPC_GREY24_LAST : NPC_CUBE6_END - 8'd1;
			end
			default: begin
				push_job.lo   = grey ? NPC_CUBE6_END : 8'd0;
				push_job.last = grey ? NPC_GREY24_LAST : NPC_CUBE6_END - 8'd1;
			end
		endcase
	end

endmodule

### sv/npc_queue.sv
// ----------------------------------------------------------------------------
// npc_queue
// Short first-in first-out queue of classified jobs between the front and
// the search engine.
// ----------------------------------------------------------------------------
module npc_queue #(
	parameter int QDEPTH = npc_pkg::NPC_QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  npc_pkg::npc_job_t push_job,
	input  logic              pop,
	output npc_pkg::npc_job_t pop_job,
	output npc_pkg::npc_qstat_t q_stat
);
	import npc_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

	npc_job_t      slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign pop_job      = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CNT_FULL);
	assign q_stat.empty = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("Job queue count exceeds its depth.");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("Job pushed into a full queue.");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("Job popped from an empty queue.");

endmodule

### sv/npc_back.sv
// ----------------------------------------------------------------------------
// npc_back
// Search engine: walks the palette entries of one job, one entry per cycle,
// through a three-stage distance pipeline and keeps the nearest entry.
// ----------------------------------------------------------------------------
module npc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  npc_pkg::npc_qstat_t q_stat,
	input  npc_pkg::npc_job_t   pop_job,
	output logic                pop,
	output logic                done,
	output logic [7:0]          color_index
);
	import npc_pkg::*;

	npc_bstate_t state_q;
	npc_bstate_t state_d;
	npc_job_t    job_q;
	logic [7:0]  idx_q;
	logic        first_q;
	logic [2:0]  cr_q;
	logic [2:0]  cg_q;
	logic [2:0]  cb_q;
	logic        issue;
	logic        is_last;
	logic        in_cube;
	logic [2:0]  cmax;
	logic [7:0]  er;
	logic [7:0]  eg;
	logic [7:0]  eb;
	logic [7:0]  gk;
	logic [7:0]  glev;

	logic        valid_s1;
	logic        first_s1;
	logic        last_s1;
	logic [7:0]  idx_s1;
	logic [7:0]  dr_s1;
	logic [7:0]  dg_s1;
	logic [7:0]  db_s1;

	logic        valid_s2;
	logic        first_s2;
	logic        last_s2;
	logic [7:0]  idx_s2;
	logic [17:0] d_s2;

	logic [7:0]  best_q;
	logic [17:0] bestd_q;
	logic        upd;
	logic        done_q;
	logic [7:0]  color_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				issue = 1'b1;
				if (idx_q == job_q.last) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		is_last = (idx_q == job_q.last);
		cmax    = (job_q.mode == PM_XTERM88) ? 3'd3 : 3'd5;
		in_cube = (idx_q >= NPC_SYS_LEN) &&
			((job_q.mode == PM_XTERM88) ? (idx_q < NPC_CUBE4_END) : (idx_q < NPC_CUBE6_END));
		gk   = idx_q - NPC_CUBE6_END;
		glev = NPC_GREY24_BASE + 8'(gk[4:0]) * NPC_GREY24_STEP;
		if (idx_q < NPC_SYS_LEN) begin
			{er, eg, eb} = (job_q.mode == PM_WIN256) ? NPC_WIN_SYS[idx_q[3:0]]
				: NPC_XTERM_SYS[idx_q[3:0]];
		end else if (job_q.mode == PM_XTERM88) begin
			if (idx_q < NPC_CUBE4_END) begin
				er = NPC_CUBE4[cr_q[1:0]];
				eg = NPC_CUBE4[cg_q[1:0]];
				eb = NPC_CUBE4[cb_q[1:0]];
			end else begin
				er = NPC_GREY8[idx_q[2:0]];
				eg = er;
				eb = er;
			end
		end else if (idx_q < NPC_CUBE6_END) begin
			er = NPC_CUBE6[cr_q];
			eg = NPC_CUBE6[cg_q];
			eb = NPC_CUBE6[cb_q];
		end else begin
			er = glev;
			eg = glev;
			eb = glev;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q   <= pop_job;
			idx_q   <= pop_job.lo;
			first_q <= 1'b1;
			cr_q    <= 3'd0;
			cg_q    <= 3'd0;
			cb_q    <= 3'd0;
		end else if (issue) begin
			idx_q   <= idx_q + 8'd1;
			first_q <= 1'b0;
			if (in_cube) begin
				if (cb_q == cmax) begin
					cb_q <= 3'd0;
					if (cg_q == cmax) begin
						cg_q <= 3'd0;
						cr_q <= cr_q + 3'd1;
					end else begin
						cg_q <= cg_q + 3'd1;
					end
				end else begin
					cb_q <= cb_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= first_q;
		last_s1  <= is_last;
		idx_s1   <= idx_q;
		dr_s1    <= (job_q.red > er) ? job_q.red - er : er - job_q.red;
		dg_s1    <= (job_q.green > eg) ? job_q.green - eg : eg - job_q.green;
		db_s1    <= (job_q.blue > eb) ? job_q.blue - eb : eb - job_q.blue;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;
		d_s2     <= 18'(16'(dr_s1) * 16'(dr_s1)) + 18'(16'(dg_s1) * 16'(dg_s1))
			+ 18'(16'(db_s1) * 16'(db_s1));
	end

	assign upd = first_s2 || (d_s2 < bestd_q);

	always_ff @(posedge clk) begin
		if (valid_s2 && upd) begin
			best_q  <= idx_s2;
			bestd_q <= d_s2;
		end
		color_index_q <= upd ? idx_s2 : best_q;
	end

	assign done        = done_q;
	assign color_index = color_index_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN) |-> (idx_q <= job_q.last))
		else $error("Search index ran past the end of its range.");

	a_pop_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == BK_RUN) && first_q)
		else $error("Popped job did not start a search.");

	a_last_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> ##1 done)
		else $error("Last entry of a search did not produce a result.");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && is_last) |=> !issue)
		else $error("Search issued entries after its last entry.");

endmodule

### sv/nearest_palette_color.sv
// ----------------------------------------------------------------------------
// nearest_palette_color
// Returns the index of the terminal palette entry nearest to an RGB color by
// squared Euclidean distance; the earliest entry wins on ties.
// ----------------------------------------------------------------------------
//   Channel   Ports                              Handshake
//   input     start, busy, red, green, blue      taken when start && !busy
//   result    done, color_index                  one-cycle strobe on done
//   config    cfg_wr_en, cfg_wr_data             written when cfg_wr_en
//
// The search engine visits one palette entry per cycle while a search runs
// and pops each job from the queue in its idle state first. The result of
// the last entry passes the two distance stages and the output register.
// A two-entry job queue lets start be taken while a search runs; busy is
// high only when the queue is full. The receiver cannot stall.
// Reset clears the palette mode to xterm 256 and empties the queue.
// ----------------------------------------------------------------------------
module nearest_palette_color #(
	parameter int QDEPTH = npc_pkg::NPC_QDEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	output logic       done,
	output logic [7:0] color_index
);
	import npc_pkg::*;

	npc_qstat_t q_stat;
	npc_job_t   push_job;
	npc_job_t   pop_job;
	logic       push;
	logic       pop;

	npc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_stat      (q_stat),
		.push        (push),
		.push_job    (push_job)
	);

	npc_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	npc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.pop_job     (pop_job),
		.pop         (pop),
		.done        (done),
		.color_index (color_index)
	);

	assign busy = q_stat.full;

endmodule
